@@ rtl/vlbs_pkg.sv @@
// vlbs_pkg: shared types, constants and helpers of the video line bit slicer
// no dependencies; every other file but vlbs_ram refers to it, the design files by scoped names
`default_nettype none

package vlbs_pkg;

    // default for the top-level parameter
    localparam int BITS_PER_ROW_DEF = 24;

    // fixed geometry of the video format
    localparam int LINE_WIDTH  = 640;
    localparam int FIELD_LINES = 240;

    // reciprocal for the field split: q = (v * FL_MULT) >> FL_SHIFT, then one correction
    localparam int FL_SHIFT  = 18;
    localparam int FL_MULT   = (1 << FL_SHIFT) / FIELD_LINES;
    localparam int FL_MULT_W = FL_SHIFT + 1;

    // payload widths
    localparam int LEVEL_W  = 8;
    localparam int LINE_W   = 9;
    localparam int COL_W    = 10;
    localparam int IDX_W    = 5;
    localparam int LABEL_W  = 8;
    localparam int SYM_W    = 2;
    localparam int SUM_W    = 18;
    localparam int CNT_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(LINE_WIDTH - 1);

    // configuration register reset values
    localparam logic [LEVEL_W-1:0] WHITE_RST = 8'd161;
    localparam logic [LEVEL_W-1:0] BLACK_RST = 8'd16;
    localparam logic [LINE_W-1:0]  FIRST_RST = 9'd90;
    localparam logic [LINE_W-1:0]  LAST_RST  = 9'd460;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WHITE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST  = 2'd3;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // symbol codes
    localparam logic [SYM_W-1:0] SYM_ZERO    = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ONE     = 2'd1;
    localparam logic [SYM_W-1:0] SYM_INVALID = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_LINE,
        ST_FETCH,
        ST_BOUND,
        ST_CHECK,
        ST_FLUSH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic div_step;
        logic rem_step;
        logic line_start;
        logic bound_load;
        logic accumulate;
        logic emit;
        logic clear_active;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic item_load;
        logic col_zero;
        logic active;
        logic active_next;
        logic at_end;
        logic col_ge_hi;
        logic eol;
        logic slot_free;
    } t_status;

    // limit a column to the last column of the line
    function automatic logic [COL_W-1:0] f_clamp_col(input logic [COL_W-1:0] x);
        logic [COL_W:0] wide;
        wide = {1'b0, x};
        return (wide >= (COL_W+1)'(LINE_WIDTH)) ? COL_LAST : x;
    endfunction

endpackage

`default_nettype wire

@@ rtl/vlbs_if.sv @@
// vlbs_if: valid/ready channel interfaces of the bit slicer (input items, result items)
// depends on vlbs_pkg for the payload widths
`default_nettype none

interface vlbs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [vlbs_pkg::IDX_W-1:0]   border_index;
    logic [vlbs_pkg::COL_W-1:0]   border_value;
    logic [vlbs_pkg::LINE_W-1:0]  video_line;
    logic [vlbs_pkg::COL_W-1:0]   column;
    logic [vlbs_pkg::LEVEL_W-1:0] pixel;
    logic                         end_of_line;

    modport source (
        output valid, kind, border_index, border_value, video_line, column, pixel,
               end_of_line,
        input  ready
    );
    modport sink (
        input  valid, kind, border_index, border_value, video_line, column, pixel,
               end_of_line,
        output ready
    );
endinterface

interface vlbs_out_if;
    logic                         valid;
    logic                         ready;
    logic [vlbs_pkg::LABEL_W-1:0] line_label;
    logic [vlbs_pkg::IDX_W-1:0]   bit_index;
    logic [vlbs_pkg::SYM_W-1:0]   symbol;
    logic                         last;

    modport source (
        output valid, line_label, bit_index, symbol, last,
        input  ready
    );
    modport sink (
        input  valid, line_label, bit_index, symbol, last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/vlbs_ram.sv @@
// vlbs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module vlbs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/vlbs_ctrl.sv @@
// vlbs_ctrl: sequencing state machine of the bit slicer
// depends on vlbs_pkg (state enum, command and status structs)
`default_nettype none

module vlbs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire vlbs_pkg::t_status i_status,
    output vlbs_pkg::t_cmd         o_cmd
);

    vlbs_pkg::t_state r_state, n_state;
    logic             r_bnd_ok, n_bnd_ok;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vlbs_pkg::ST_IDLE;
            r_bnd_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bnd_ok <= n_bnd_ok;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_bnd_ok   = r_bnd_ok;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            vlbs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_status.item_load) begin
                        // border table changed, window bounds must be fetched again
                        o_cmd.load_wr = 1'b1;
                        n_bnd_ok      = 1'b0;
                    end else begin
                        o_cmd.capture = 1'b1;
                        if (i_status.col_zero) begin
                            n_state = vlbs_pkg::ST_DIV;
                        end else if (!i_status.active) begin
                            n_state = vlbs_pkg::ST_IDLE;
                        end else if (i_status.at_end || r_bnd_ok) begin
                            n_state = vlbs_pkg::ST_CHECK;
                        end else begin
                            n_state = vlbs_pkg::ST_FETCH;
                        end
                    end
                end
            end
            vlbs_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = vlbs_pkg::ST_REM;
            end
            vlbs_pkg::ST_REM: begin
                o_cmd.rem_step = 1'b1;
                n_state        = vlbs_pkg::ST_LINE;
            end
            vlbs_pkg::ST_LINE: begin
                o_cmd.line_start = 1'b1;
                n_bnd_ok         = 1'b0;
                n_state = i_status.active_next ? vlbs_pkg::ST_FETCH : vlbs_pkg::ST_IDLE;
            end
            vlbs_pkg::ST_FETCH: begin
                n_state = vlbs_pkg::ST_BOUND;
            end
            vlbs_pkg::ST_BOUND: begin
                o_cmd.bound_load = 1'b1;
                n_bnd_ok         = 1'b1;
                n_state          = vlbs_pkg::ST_CHECK;
            end
            vlbs_pkg::ST_CHECK: begin
                if (i_status.at_end) begin
                    o_cmd.clear_active = i_status.eol;
                    n_state            = vlbs_pkg::ST_IDLE;
                end else if (i_status.col_ge_hi) begin
                    // close the current window, then look at the next one
                    if (i_status.slot_free) begin
                        o_cmd.emit = 1'b1;
                        n_bnd_ok   = 1'b0;
                        n_state    = vlbs_pkg::ST_FETCH;
                    end
                end else begin
                    o_cmd.accumulate = 1'b1;
                    n_state = i_status.eol ? vlbs_pkg::ST_FLUSH : vlbs_pkg::ST_IDLE;
                end
            end
            vlbs_pkg::ST_FLUSH: begin
                if (i_status.at_end) begin
                    o_cmd.clear_active = 1'b1;
                    n_state            = vlbs_pkg::ST_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_bnd_ok   = 1'b0;
                end
            end
            default: begin
                n_state = vlbs_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // a bit is only closed when the result register can take it
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.slot_free)
        else $error("emit without free result slot");

    // window compare only runs on bounds of the current bit
    a_check_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vlbs_pkg::ST_CHECK && !i_status.at_end) |-> r_bnd_ok)
        else $error("window check with stale bounds");

    // flushing only happens on an active line
    a_flush_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vlbs_pkg::ST_FLUSH) |-> i_status.active)
        else $error("flush on inactive line");
`endif

endmodule

`default_nettype wire

@@ rtl/vlbs_dp.sv @@
// vlbs_dp: datapath of the bit slicer: config registers, border table, line mapping,
// window accumulator, classification and result register; depends on vlbs_pkg, vlbs_ram
`default_nettype none

module vlbs_dp #(
    parameter int BITS_PER_ROW = vlbs_pkg::BITS_PER_ROW_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire vlbs_pkg::t_cmd                    i_cmd,
    output vlbs_pkg::t_status                      o_status,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [vlbs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [vlbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input payload
    input  wire logic                              i_kind,
    input  wire logic [vlbs_pkg::IDX_W-1:0]        i_border_index,
    input  wire logic [vlbs_pkg::COL_W-1:0]        i_border_value,
    input  wire logic [vlbs_pkg::LINE_W-1:0]       i_video_line,
    input  wire logic [vlbs_pkg::COL_W-1:0]        i_column,
    input  wire logic [vlbs_pkg::LEVEL_W-1:0]      i_pixel,
    input  wire logic                              i_end_of_line,
    // result register
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic      [vlbs_pkg::LABEL_W-1:0]      o_line_label,
    output logic      [vlbs_pkg::IDX_W-1:0]        o_bit_index,
    output logic      [vlbs_pkg::SYM_W-1:0]        o_symbol,
    output logic                                   o_last
);

    localparam int DEPTH = BITS_PER_ROW + 1;
    localparam int CB_W  = $clog2(DEPTH);
    localparam int MW    = vlbs_pkg::LINE_W + vlbs_pkg::FL_MULT_W;
    localparam int RPW   = 2 * vlbs_pkg::COL_W;
    localparam int CW    = vlbs_pkg::COL_W;
    localparam int LW    = vlbs_pkg::LINE_W;
    localparam int VW    = vlbs_pkg::LEVEL_W;
    localparam int NW    = vlbs_pkg::CNT_W;
    localparam int SW    = vlbs_pkg::SUM_W;

    localparam logic [CB_W-1:0] BIT_END  = CB_W'(BITS_PER_ROW);
    localparam logic [CB_W-1:0] BIT_LAST = CB_W'(BITS_PER_ROW - 1);

    // configuration registers
    logic [VW-1:0] r_white, r_black;
    logic [LW-1:0] r_first, r_last;

    // captured pixel item
    logic [LW-1:0] r_v;
    logic [CW-1:0] r_col;
    logic [VW-1:0] r_pix;
    logic          r_eol;

    // line mapping
    logic [CW-1:0] r_q;
    logic [CW:0]   r_rem;
    logic [7:0]    r_label;
    logic          r_active;

    // window state
    logic [CB_W-1:0] r_cur_bit;
    logic [CW-1:0]   r_lo, r_hi;
    logic [SW-1:0]   r_sum;
    logic [VW-1:0]   r_max, r_min;
    logic [NW-1:0]   r_cnt;

    // result register
    logic                          r_out_valid;
    logic [vlbs_pkg::LABEL_W-1:0]  r_out_label;
    logic [vlbs_pkg::IDX_W-1:0]    r_out_bit;
    logic [vlbs_pkg::SYM_W-1:0]    r_out_sym;
    logic                          r_out_last;

    logic n_out_valid;

    // border table: two copies so left and right border are read together
    logic            w_we;
    logic [CB_W-1:0] w_waddr, w_raddr_r;
    logic [CW-1:0]   w_bl, w_br;
    logic            w_at_end;

    assign w_at_end  = (r_cur_bit == BIT_END);
    assign w_we      = i_cmd.load_wr && ({1'b0, i_border_index} <= 6'(BITS_PER_ROW));
    assign w_waddr   = CB_W'(i_border_index);
    assign w_raddr_r = w_at_end ? r_cur_bit : r_cur_bit + 1'b1;

    vlbs_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_left (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_border_value),
        .i_raddr (r_cur_bit),
        .o_rdata (w_bl)
    );

    vlbs_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_right (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_border_value),
        .i_raddr (w_raddr_r),
        .o_rdata (w_br)
    );

    // window bounds: middle half between the borders, clamped to the line
    logic [CW:0]   w_bsum, w_lsum, w_rsum;
    logic [CW-1:0] w_bmid, w_lo, w_hi;
    always_comb begin
        w_bsum = {1'b0, w_bl} + {1'b0, w_br};
        w_bmid = w_bsum[CW:1];
        w_lsum = {1'b0, w_bl} + {1'b0, w_bmid};
        w_rsum = {1'b0, w_br} + {1'b0, w_bmid};
        w_lo   = vlbs_pkg::f_clamp_col(w_lsum[CW:1]);
        w_hi   = vlbs_pkg::f_clamp_col(w_rsum[CW:1]);
    end

    // deinterlace: quotient estimate, remainder, then one correction step
    logic [MW-1:0]  w_qprod;
    logic [RPW-1:0] w_rprod, w_rem0;
    logic           w_fix;
    logic [CW:0]    w_rem;
    logic [CW-1:0]  w_qf;
    logic [11:0]    w_il;
    logic           w_active_next;
    always_comb begin
        w_qprod = MW'(r_v) * MW'(vlbs_pkg::FL_MULT);
        w_rprod = RPW'(r_q) * RPW'(vlbs_pkg::FIELD_LINES);
        w_rem0  = RPW'(r_v) - w_rprod;
        w_fix   = (r_rem >= (CW+1)'(vlbs_pkg::FIELD_LINES));
        w_rem   = w_fix ? r_rem - (CW+1)'(vlbs_pkg::FIELD_LINES) : r_rem;
        w_qf    = r_q + CW'(w_fix);
        w_il    = 12'({w_rem[CW-1:0], 1'b0}) + 12'(w_qf);
        w_active_next = (w_il >= 12'(r_first)) && (w_il <= 12'(r_last));
    end

    // classification of the current window
    logic [VW-1:0]    w_diff;
    logic [VW:0]      w_span, w_lvl_sum;
    logic [VW-1:0]    w_range;
    logic [VW:0]      w_thr;
    logic [SW:0]      w_thr_cnt;
    logic [vlbs_pkg::SYM_W-1:0] w_sym;
    always_comb begin
        w_diff    = (r_white >= r_black) ? r_white - r_black : r_black - r_white;
        w_span    = {2'b0, w_diff[VW-1:2], 1'b0} + (VW+1)'(w_diff[VW-1:2]);
        w_range   = r_max - r_min;
        w_lvl_sum = {1'b0, r_white} + {1'b0, r_black};
        w_thr     = (VW+1)'(w_lvl_sum[VW:1]) + 1'b1;
        // floor(sum/count) > mid  <=>  sum >= (mid+1)*count
        w_thr_cnt = (SW+1)'(w_thr) * (SW+1)'(r_cnt);
        if (r_cnt == '0) begin
            w_sym = vlbs_pkg::SYM_INVALID;
        end else if ({1'b0, w_range} > w_span) begin
            w_sym = vlbs_pkg::SYM_INVALID;
        end else if ({1'b0, r_sum} >= w_thr_cnt) begin
            w_sym = vlbs_pkg::SYM_ZERO;
        end else begin
            w_sym = vlbs_pkg::SYM_ONE;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white <= vlbs_pkg::WHITE_RST;
            r_black <= vlbs_pkg::BLACK_RST;
            r_first <= vlbs_pkg::FIRST_RST;
            r_last  <= vlbs_pkg::LAST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vlbs_pkg::REG_WHITE: r_white <= i_cfg_data[VW-1:0];
                vlbs_pkg::REG_BLACK: r_black <= i_cfg_data[VW-1:0];
                vlbs_pkg::REG_FIRST: r_first <= i_cfg_data[LW-1:0];
                vlbs_pkg::REG_LAST:  r_last  <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    // item capture, mapping steps and bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_v   <= i_video_line;
            r_col <= i_column;
            r_pix <= i_pixel;
            r_eol <= i_end_of_line;
        end
        if (i_cmd.div_step) begin
            r_q <= w_qprod[vlbs_pkg::FL_SHIFT +: CW];
        end
        if (i_cmd.rem_step) begin
            r_rem <= w_rem0[CW:0];
        end
        if (i_cmd.bound_load) begin
            r_lo <= w_lo;
            r_hi <= w_hi;
        end
        if (i_cmd.line_start) begin
            r_label <= w_il[8:1];
        end
    end

    // line and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_cur_bit <= '0;
            r_sum     <= '0;
            r_max     <= '0;
            r_min     <= '1;
            r_cnt     <= '0;
        end else begin
            if (i_cmd.line_start) begin
                r_active <= w_active_next;
            end else if (i_cmd.clear_active) begin
                r_active <= 1'b0;
            end
            if (i_cmd.line_start || i_cmd.emit) begin
                r_cur_bit <= i_cmd.line_start ? '0 : r_cur_bit + 1'b1;
                r_sum     <= '0;
                r_max     <= '0;
                r_min     <= '1;
                r_cnt     <= '0;
            end else if (i_cmd.accumulate && r_col >= r_lo &&
                         r_cnt != vlbs_pkg::COUNT_MAX) begin
                r_sum <= r_sum + SW'(r_pix);
                r_cnt <= r_cnt + 1'b1;
                if (r_pix > r_max) begin
                    r_max <= r_pix;
                end
                if (r_pix < r_min) begin
                    r_min <= r_pix;
                end
            end
        end
    end

    // result register
    always_comb begin
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (i_cmd.emit) begin
            r_out_label <= r_label;
            r_out_bit   <= vlbs_pkg::IDX_W'(r_cur_bit);
            r_out_sym   <= w_sym;
            r_out_last  <= (r_cur_bit == BIT_LAST);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_label = r_out_label;
    assign o_bit_index  = r_out_bit;
    assign o_symbol     = r_out_sym;
    assign o_last       = r_out_last;

    // status to the controller
    always_comb begin
        o_status.item_load   = (i_kind == vlbs_pkg::KIND_LOAD);
        o_status.col_zero    = (i_column == '0);
        o_status.active      = r_active;
        o_status.active_next = w_active_next;
        o_status.at_end      = w_at_end;
        o_status.col_ge_hi   = (r_col >= r_hi);
        o_status.eol         = r_eol;
        o_status.slot_free   = !r_out_valid || i_out_ready;
    end

`ifndef ASSERT_OFF
    // bit counter never runs past the end of the row
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_bit <= BIT_END)
        else $error("bit counter past end of row");

    // a non-empty window has consistent extremes
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_min <= r_max))
        else $error("window min above max");

    // a closed bit shows up at the result register
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("closed bit lost");
`endif

endmodule

`default_nettype wire

@@ rtl/video_line_bit_slicer_top.sv @@
// video_line_bit_slicer_top: top level of the video line bit slicer
// depends on vlbs_pkg, vlbs_if, vlbs_ram, vlbs_ctrl, vlbs_dp
//
//   port       dir  handshake        beat
//   i_pix      in   valid/ready      border load or pixel with line, column, end of line
//   o_res      out  valid/ready      line label, bit index, symbol, last flag
//   i_cfg_*    in   write enable     register index and data, no read-back
//
// a pixel that closes no window: accept, window check; bounds fetch first after table load
// each closed window adds a result load, a border table read and a bounds register load
// column 0 adds the line mapping steps (divide, remainder, line start) and a bounds read
// pixel of an undecoded line: accept only (column 0: also mapping); border load: write only
// end of line flushes the remaining bits at one per cycle while the result slot is free
// synchronous active-low reset, no clearing pass; a waiting result stalls closing and input
`default_nettype none

module video_line_bit_slicer_top #(
    parameter int BITS_PER_ROW = vlbs_pkg::BITS_PER_ROW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    vlbs_in_if.sink                              i_pix,
    vlbs_out_if.source                           o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [vlbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [vlbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    vlbs_pkg::t_cmd    w_cmd;
    vlbs_pkg::t_status w_status;
    logic              w_in_ready;

    assign i_pix.ready = w_in_ready;

    // sequencer
    vlbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    vlbs_dp #(.BITS_PER_ROW(BITS_PER_ROW)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_pix.kind),
        .i_border_index (i_pix.border_index),
        .i_border_value (i_pix.border_value),
        .i_video_line   (i_pix.video_line),
        .i_column       (i_pix.column),
        .i_pixel        (i_pix.pixel),
        .i_end_of_line  (i_pix.end_of_line),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_line_label   (o_res.line_label),
        .o_bit_index    (o_res.bit_index),
        .o_symbol       (o_res.symbol),
        .o_last         (o_res.last)
    );

endmodule

`default_nettype wire

@@ verif/video_line_bit_slicer_top_tb.sv @@
// video_line_bit_slicer_top_tb: self-checking bench for the video line bit slicer
// depends on vlbs_pkg, vlbs_if and video_line_bit_slicer_top; a local slicer model predicts
// every result beat, with random gaps on both channels and register settings between phases
`timescale 1ns / 100ps

module video_line_bit_slicer_top_tb;
    import vlbs_pkg::*;

    localparam int NBITS     = BITS_PER_ROW_DEF;
    localparam int SETTLE    = 150;    // cycles a beat without result may still be in flight
    localparam int STALL_LEN = 400;    // long receiver hold-off
    localparam int IDLE_PCT  = 29;
    localparam int WATCHDOG  = 4000;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   border_index;
        logic [COL_W-1:0]   border_value;
        logic [LINE_W-1:0]  video_line;
        logic [COL_W-1:0]   column;
        logic [LEVEL_W-1:0] pixel;
        logic               end_of_line;
    } t_beat;

    localparam int BEAT_W = $bits(t_beat);

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [IDX_W-1:0]   idx;
        logic [SYM_W-1:0]   sym;
        logic               last;
    } t_symbol;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    vlbs_in_if  pix_if ();
    vlbs_out_if res_if ();

    video_line_bit_slicer_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // stimulus and expectation stores
    t_beat   pixel_stream [$];
    t_symbol symbols_due [$];
    t_beat   next_beat;
    t_beat   seen_beat;
    t_symbol want;

    bit steady = 1'b0;      // no idling on either side
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int errors = 0;
    int beats_taken = 0;
    int symbols_seen = 0;
    int settings = 0;
    int quiet = 0;

    // slicer model state
    logic [COL_W-1:0]   border_tab [NBITS+1];
    int unsigned        cur_bit;
    int unsigned        w_sum, w_max, w_min, w_cnt;
    logic               line_on;
    logic [LABEL_W-1:0] cur_label;
    logic [LEVEL_W-1:0] white_lvl, black_lvl;
    logic [LINE_W-1:0]  first_ln, last_ln;

    function automatic int unsigned clamp_column(int unsigned x);
        return (x >= LINE_WIDTH) ? LINE_WIDTH - 1 : x;
    endfunction

    function automatic void window_edges(int unsigned b, output int unsigned lo,
                                         output int unsigned hi);
        int unsigned l, r, m;
        l = border_tab[b];
        r = border_tab[b+1];
        m = (l + r) / 2;
        lo = clamp_column((l + m) / 2);
        hi = clamp_column((r + m) / 2);
    endfunction

    function automatic void clear_window();
        w_sum = 0;
        w_max = 0;
        w_min = 255;
        w_cnt = 0;
    endfunction

    // empty or too noisy windows are invalid, else compare the mean with the midpoint
    function automatic logic [SYM_W-1:0] judge_window();
        int unsigned wl, bl, span;
        wl = white_lvl;
        bl = black_lvl;
        if (w_cnt == 0) return SYM_INVALID;
        span = ((wl >= bl) ? wl - bl : bl - wl) / 4 * 3;
        if (w_max - w_min > span) return SYM_INVALID;
        return (w_sum / w_cnt > (wl + bl) / 2) ? SYM_ZERO : SYM_ONE;
    endfunction

    function automatic void close_window();
        t_symbol s;
        s.label = cur_label;
        s.idx   = IDX_W'(cur_bit);
        s.sym   = judge_window();
        s.last  = (cur_bit == NBITS - 1);
        symbols_due.push_back(s);
        cur_bit++;
        clear_window();
    endfunction

    // advance the model by one accepted beat, queueing the bits it closes
    function automatic void slice_beat(t_beat b);
        int unsigned col, v, img, lo, hi;
        if (b.kind == KIND_LOAD) begin
            if (b.border_index <= NBITS) border_tab[b.border_index] = b.border_value;
            return;
        end
        col = b.column;
        if (col == 0) begin
            v = b.video_line;
            img = (v % FIELD_LINES) * 2 + v / FIELD_LINES;
            cur_label = LABEL_W'(img / 2);
            line_on = (img >= first_ln) && (img <= last_ln);
            cur_bit = 0;
            clear_window();
        end
        if (!line_on) return;
        while (cur_bit < NBITS) begin
            window_edges(cur_bit, lo, hi);
            if (col < hi) break;
            close_window();
        end
        if (cur_bit < NBITS) begin
            window_edges(cur_bit, lo, hi);
            if (col >= lo && col < hi && w_cnt < COUNT_MAX) begin
                w_sum += b.pixel;
                w_cnt++;
                if (b.pixel > w_max) w_max = b.pixel;
                if (b.pixel < w_min) w_min = b.pixel;
            end
        end
        if (b.end_of_line) begin
            while (cur_bit < NBITS) close_window();
            line_on = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // input driver: next beat from the stream, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (pixel_stream.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_beat = pixel_stream.pop_front();
                pix_if.valid        <= 1'b1;
                pix_if.kind         <= next_beat.kind;
                pix_if.border_index <= next_beat.border_index;
                pix_if.border_value <= next_beat.border_value;
                pix_if.video_line   <= next_beat.video_line;
                pix_if.column       <= next_beat.column;
                pix_if.pixel        <= next_beat.pixel;
                pix_if.end_of_line  <= next_beat.end_of_line;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // accepted input beats feed the model
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            seen_beat.kind         = pix_if.kind;
            seen_beat.border_index = pix_if.border_index;
            seen_beat.border_value = pix_if.border_value;
            seen_beat.video_line   = pix_if.video_line;
            seen_beat.column       = pix_if.column;
            seen_beat.pixel        = pix_if.pixel;
            seen_beat.end_of_line  = pix_if.end_of_line;
            slice_beat(seen_beat);
            beats_taken++;
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = STALL_LEN;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            symbols_seen++;
            if (symbols_due.size() == 0) begin
                $error("unexpected result beat: label %0d bit %0d symbol %0d",
                       res_if.line_label, res_if.bit_index, res_if.symbol);
                errors++;
            end else begin
                want = symbols_due.pop_front();
                check_field("line_label", want.label, res_if.line_label);
                check_field("bit_index", want.idx, res_if.bit_index);
                check_field("symbol", want.sym, res_if.symbol);
                check_field("last", want.last, res_if.last);
            end
        end
    end

    // watchdog on cycles where no beat moves
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // stimulus builders
    function automatic void push_load(int unsigned idx, int unsigned val);
        t_beat b;
        b = BEAT_W'({$urandom, $urandom});
        b.kind = KIND_LOAD;
        b.border_index = IDX_W'(idx);
        b.border_value = COL_W'(val);
        pixel_stream.push_back(b);
    endfunction

    function automatic void push_pixel(int unsigned v, int unsigned col, int unsigned pix,
                                       bit eol);
        t_beat b;
        b = BEAT_W'({$urandom, $urandom});
        b.kind = KIND_PIXEL;
        b.video_line = LINE_W'(v);
        b.column = COL_W'(col);
        b.pixel = LEVEL_W'(pix);
        b.end_of_line = eol;
        pixel_stream.push_back(b);
    endfunction

    // mostly near white or black, sometimes anything
    function automatic int unsigned shade();
        int r, p;
        r = $urandom_range(99);
        if (r >= 90) return $urandom_range(255);
        p = (r < 45) ? int'(white_lvl) : int'(black_lvl);
        p = p + int'($urandom_range(16)) - 8;
        return (p < 0) ? 0 : (p > 255) ? 255 : p;
    endfunction

    function automatic void push_table(bit ascending);
        int unsigned start, step, i, val;
        start = $urandom_range(60);
        step = $urandom_range(10, 28);
        for (i = 0; i <= NBITS; i++) begin
            val = ascending ? start + i * step + $urandom_range(4) : $urandom_range(1023);
            push_load(i, (val > 1023) ? 1023 : val);
        end
    endfunction

    function automatic void push_line(int unsigned pix_cnt, bit with_eol);
        int unsigned v, col, k;
        v = $urandom_range(479);
        col = 0;
        for (k = 0; k < pix_cnt; k++) begin
            if (k != 0) begin
                col += $urandom_range(1, 1280 / pix_cnt);
                if (col > LINE_WIDTH - 1) col = LINE_WIDTH - 1;
            end
            push_pixel(v, col, shade(), with_eol && (k == pix_cnt - 1));
        end
    endfunction

    // random part: mostly whole lines, some stray pixels and table writes
    function automatic void push_random(int unsigned count);
        int unsigned start, r;
        start = pixel_stream.size();
        while (pixel_stream.size() - start < count) begin
            r = $urandom_range(99);
            if (r < 75)
                push_line(($urandom_range(7) == 0) ? $urandom_range(30, 50)
                                                   : $urandom_range(1, 14),
                          $urandom_range(9) != 0);
            else if (r < 85)
                push_pixel($urandom_range(479), $urandom_range(1, 639), $urandom_range(255),
                           $urandom_range(1));
            else if (r < 92)
                push_load($urandom_range(31), $urandom_range(1023));
            else
                push_table($urandom_range(3) != 0);
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        case (idx)
            REG_WHITE: white_lvl = LEVEL_W'(val);
            REG_BLACK: black_lvl = LEVEL_W'(val);
            REG_FIRST: first_ln = LINE_W'(val);
            default:   last_ln = LINE_W'(val);
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_levels(int unsigned wl, int unsigned bl, int unsigned fl, int unsigned ll);
        write_reg(REG_WHITE, wl);
        write_reg(REG_BLACK, bl);
        write_reg(REG_FIRST, fl);
        write_reg(REG_LAST, ll);
        settings++;
    endtask

    // wait for the stream to empty and every result to arrive, then let the block settle
    task automatic drain();
        do @(posedge i_clk);
        while (pixel_stream.size() != 0 || pix_if.valid || symbols_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int i;
        pix_if.valid = 1'b0;
        pix_if.kind = KIND_LOAD;
        pix_if.border_index = '0;
        pix_if.border_value = '0;
        pix_if.video_line = '0;
        pix_if.column = '0;
        pix_if.pixel = '0;
        pix_if.end_of_line = 1'b0;
        res_if.ready = 1'b0;

        // model reset
        white_lvl = WHITE_RST;
        black_lvl = BLACK_RST;
        first_ln = FIRST_RST;
        last_ln = LAST_RST;
        for (i = 0; i <= NBITS; i++) border_tab[i] = '0;
        cur_bit = 0;
        clear_window();
        line_on = 1'b0;
        cur_label = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: regular table with one border out of order and a clamped last window
        for (i = 0; i <= NBITS; i++)
            push_load(i, (i == 10) ? 0 : (i == NBITS) ? 1023 : 24 + 24 * i);
        push_load(25, 5);                 // index past the table, ignored
        push_load(31, 1023);
        push_pixel(100, 5, 77, 0);        // no line started yet
        push_pixel(100, 0, 0, 0);         // image line 200, decoded
        push_pixel(100, 35, 255, 0);
        push_pixel(100, 36, 250, 0);
        push_pixel(100, 60, 0, 0);        // closes bit 0
        push_pixel(479, 0, 9, 0);         // new line drops pending bits, line 479 skipped
        push_pixel(479, 100, 200, 1);
        push_pixel(45, 0, 128, 0);        // image line 90, first decoded line
        push_pixel(45, 110, 130, 0);
        push_pixel(45, 111, 20, 0);       // too much spread in one window
        push_pixel(45, 160, 20, 0);
        push_pixel(45, 639, 255, 1);      // flush the rest
        push_pixel(230, 0, 16, 0);        // image line 460, last decoded line
        push_pixel(230, 300, 16, 1);
        push_pixel(44, 0, 0, 1);          // image line 88, below the range
        push_pixel(256, 0, 255, 0);
        push_pixel(256, 512, 255, 1);
        push_pixel(239, 0, 254, 1);       // image line 478, above the range
        push_pixel(200, 0, 100, 1);       // end of line on column 0, all windows empty
        push_pixel(200, 7, 3, 0);         // after end of line, ignored
        drain();

        // full-scale levels, every line decoded
        set_levels(255, 0, 0, 479);
        push_random(25);
        drain();

        // inverted levels, narrow range, no idling
        set_levels(0, 255, 200, 300);
        steady = 1'b1;
        push_random(30);
        drain();
        steady = 1'b0;

        // equal levels, and a long receiver hold-off while a dense line keeps coming
        set_levels(100, 100, 0, 479);
        push_random(10);
        hold_asked++;
        push_line(30, 1'b1);
        drain();

        // empty range: nothing is decoded
        set_levels(200, 40, 479, 0);
        push_random(10);
        drain();

        // back to reset levels
        set_levels(WHITE_RST, BLACK_RST, FIRST_RST, LAST_RST);
        push_random(20);
        drain();

        $display("covered %0d input beats and %0d result beats over %0d register settings",
                 beats_taken, symbols_seen, settings + 1);
        $display("phases: directed lines, level extremes, empty range, hold-off, reset levels");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
